@@ hw/rtl/wsdf_pkg.sv @@
package wsdf_pkg;

    localparam logic [7:0] FIN_MASK      = 8'h80;
    localparam logic [6:0] LEN_CODE_MAX  = 7'd125;
    localparam logic [6:0] LEN_CODE_16   = 7'd126;
    localparam logic [6:0] LEN_CODE_64   = 7'd127;
    localparam logic [3:0] EXT_BYTES_16  = 4'd2;
    localparam logic [3:0] EXT_BYTES_64  = 4'd8;
    localparam logic [2:0] KEY_BYTES     = 3'd4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       data_valid;
        logic       fin_flag;
        logic [2:0] reserved_bits;
        logic [3:0] frame_opcode;
        logic       masked_flag;
        logic       last_of_frame;
    } result_t;

endpackage

@@ hw/rtl/websocket_frame_deframer_core.sv @@
// Receive-side WebSocket frame deframer. The input channel (in_valid, in_stall,
// data_byte) carries the raw frame stream, one byte per word, with frames
// following each other without gaps. The output channel (out_valid, out_stall)
// carries one result word per payload byte of a masked frame, unmasked with
// the frame's key, plus one header-only word that closes each empty or unmasked
// frame at its last byte; every word also reports the header fields and length.
// Each accepted byte is parsed in the cycle it is taken, and its result word
// appears on the output register in the next cycle. One byte is accepted every
// cycle while in_stall is low; the rate is set by the header state machine and
// the payload length compare. Other header, length and key bytes yield no word.
// Reset returns the parser to the first header byte of a new frame and
// empties the output register. While the receiver stalls a waiting word,
// in_stall is raised and no further byte is taken until the word is accepted.
// LENGTH_BITS sets the width kept of the decoded payload length.
module websocket_frame_deframer_core
    import wsdf_pkg::*;
#(
    parameter int LENGTH_BITS = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             payload_byte,
    output logic                   data_valid,
    output logic                   fin_flag,
    output logic [2:0]             reserved_bits,
    output logic [3:0]             frame_opcode,
    output logic                   masked_flag,
    output logic [LENGTH_BITS-1:0] payload_length,
    output logic                   last_of_frame
);

    logic                   in_fire;
    logic                   res_valid;
    result_t                res;
    logic [LENGTH_BITS-1:0] res_length;
    result_t                out_res;

    assign in_stall = out_valid & out_stall;
    assign in_fire  = in_valid & ~in_stall;

    wsdf_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .data_byte  (data_byte),
        .res_valid  (res_valid),
        .res        (res),
        .res_length (res_length)
    );

    wsdf_out_reg #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_valid),
        .res        (res),
        .res_length (res_length),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_res    (out_res),
        .out_length (payload_length)
    );

    assign payload_byte  = out_res.payload_byte;
    assign data_valid    = out_res.data_valid;
    assign fin_flag      = out_res.fin_flag;
    assign reserved_bits = out_res.reserved_bits;
    assign frame_opcode  = out_res.frame_opcode;
    assign masked_flag   = out_res.masked_flag;
    assign last_of_frame = out_res.last_of_frame;

endmodule

@@ hw/rtl/wsdf_parser.sv @@
module wsdf_parser
    import wsdf_pkg::*;
#(
    parameter int LENGTH_BITS = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_fire,
    input  logic [7:0]             data_byte,
    output logic                   res_valid,
    output result_t                res,
    output logic [LENGTH_BITS-1:0] res_length
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_DROP = 3'd5;

    logic [2:0]             phase_reg, phase_next;
    logic [7:0]             hdr_reg, hdr_next;
    logic                   mask_reg, mask_next;
    logic [3:0]             ext_left_reg, ext_left_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [31:0]            key_reg, key_next;
    logic [2:0]             key_seen_reg, key_seen_next;
    logic [LENGTH_BITS-1:0] seen_reg, seen_next;

    logic                   len_done;
    logic                   emit;
    logic                   emit_data;
    logic                   emit_last;
    logic [7:0]             emit_byte;
    logic [6:0]             code;
    logic [7:0]             key_byte;
    logic [LENGTH_BITS-1:0] seen_inc;

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_next      = hdr_reg;
        mask_next     = mask_reg;
        ext_left_next = ext_left_reg;
        len_next      = len_reg;
        key_next      = key_reg;
        key_seen_next = key_seen_reg;
        seen_next     = seen_reg;
        len_done      = 1'b0;
        emit          = 1'b0;
        emit_data     = 1'b0;
        emit_last     = 1'b0;
        emit_byte     = 8'd0;
        code          = data_byte[6:0];
        seen_inc      = seen_reg + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        case (seen_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase

        case (phase_reg)
            PH_HDR1:
            begin
                mask_next = data_byte[7];
                if (code <= LEN_CODE_MAX)
                begin
                    len_next = {{(LENGTH_BITS-7){1'b0}}, code};
                    len_done = 1'b1;
                end
                else
                begin
                    len_next      = '0;
                    ext_left_next = (code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
                    phase_next    = PH_EXT;
                end
            end
            PH_EXT:
            begin
                len_next      = {len_reg[LENGTH_BITS-9:0], data_byte};
                ext_left_next = ext_left_reg - 4'd1;
                if (ext_left_next == 4'd0)
                begin
                    len_done = 1'b1;
                end
            end
            PH_KEY:
            begin
                key_next      = {key_reg[23:0], data_byte};
                key_seen_next = key_seen_reg + 3'd1;
                if (key_seen_next >= KEY_BYTES)
                begin
                    if (len_reg == '0)
                    begin
                        phase_next = PH_HDR0;
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                seen_next = seen_inc;
                emit      = 1'b1;
                emit_data = 1'b1;
                emit_byte = data_byte ^ key_byte;
                if (seen_inc == len_reg)
                begin
                    emit_last  = 1'b1;
                    phase_next = PH_HDR0;
                end
            end
            PH_DROP:
            begin
                seen_next = seen_inc;
                if (seen_inc == len_reg)
                begin
                    phase_next = PH_HDR0;
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                end
            end
            default:
            begin
                hdr_next      = data_byte;
                mask_next     = 1'b0;
                ext_left_next = 4'd0;
                len_next      = '0;
                key_seen_next = 3'd0;
                seen_next     = '0;
                phase_next    = PH_HDR1;
            end
        endcase

        if (len_done)
        begin
            seen_next = '0;
            if (mask_next)
            begin
                key_seen_next = 3'd0;
                key_next      = 32'd0;
                phase_next    = PH_KEY;
            end
            else if (len_next == '0)
            begin
                phase_next = PH_HDR0;
                emit       = 1'b1;
                emit_last  = 1'b1;
            end
            else
            begin
                phase_next = PH_DROP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            hdr_reg      <= 8'd0;
            mask_reg     <= 1'b0;
            ext_left_reg <= 4'd0;
            len_reg      <= '0;
            key_reg      <= 32'd0;
            key_seen_reg <= 3'd0;
            seen_reg     <= '0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            hdr_reg      <= hdr_next;
            mask_reg     <= mask_next;
            ext_left_reg <= ext_left_next;
            len_reg      <= len_next;
            key_reg      <= key_next;
            key_seen_reg <= key_seen_next;
            seen_reg     <= seen_next;
        end
    end

    assign res_valid         = in_fire & emit;
    assign res.payload_byte  = emit_byte;
    assign res.data_valid    = emit_data;
    assign res.fin_flag      = |(hdr_next & FIN_MASK);
    assign res.reserved_bits = hdr_next[6:4];
    assign res.frame_opcode  = hdr_next[3:0];
    assign res.masked_flag   = mask_next;
    assign res.last_of_frame = emit_last;
    assign res_length        = len_next;

endmodule

@@ hw/rtl/wsdf_out_reg.sv @@
module wsdf_out_reg
    import wsdf_pkg::*;
#(
    parameter int LENGTH_BITS = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  result_t                res,
    input  logic [LENGTH_BITS-1:0] res_length,
    input  logic                   out_stall,
    output logic                   out_valid,
    output result_t                out_res,
    output logic [LENGTH_BITS-1:0] out_length
);

    logic                   valid_reg, valid_next;
    result_t                res_reg;
    logic [LENGTH_BITS-1:0] length_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg    <= res;
            length_reg <= res_length;
        end
    end

    assign out_valid  = valid_reg;
    assign out_res    = res_reg;
    assign out_length = length_reg;

endmodule
